// File: hdl/crc_cw_pkg.sv
package crc_cw_pkg;

	// Generator and counter sizing.
	localparam int MAX_GEN_BITS = 17;
	localparam int COUNT_BITS   = 32;

	// Remainder width is one less than the longest generator.
	localparam int REM_W = MAX_GEN_BITS - 1;

	// The gen_len register keeps the low eight bits of what is written.
	localparam int LEN_REG_W = 8;

	// Width able to hold an effective remainder length.
	localparam int LEN_W = $clog2(MAX_GEN_BITS);

	// Dataword sizes and the longest codeword.
	localparam int DW_NIBBLE = 4;
	localparam int DW_BYTE   = 8;
	localparam int CS_MAX    = DW_BYTE + REM_W;
	localparam int BP_W      = $clog2(CS_MAX + 1);

	// Pad count handling.
	localparam int SKIP_W  = 3;
	localparam int PAD_MAX = 7;

	// Width of the result counters as seen at the ports.
	localparam int TOTAL_W = 32;

	// Configuration port.
	localparam int CFG_W   = (MAX_GEN_BITS > LEN_REG_W) ? MAX_GEN_BITS : LEN_REG_W;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GEN_POLY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GEN_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_MODE = 2'd2;

	// Register reset values.
	localparam logic [MAX_GEN_BITS-1:0] GEN_POLY_RST  = MAX_GEN_BITS'(11);
	localparam logic [LEN_REG_W-1:0]    GEN_LEN_RST   = LEN_REG_W'(4);
	localparam logic                    MODE_BYTE     = 1'b1;
	localparam logic                    DATA_MODE_RST = MODE_BYTE;

	typedef struct packed {
		logic [MAX_GEN_BITS-1:0] gen_poly;
		logic [LEN_REG_W-1:0]    gen_len;
		logic                    data_mode;
	} cfg_t;

	// Stream state carried from one word to the next.
	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [BP_W-1:0]   bit_pos;
		logic [7:0]        data;
		logic [3:0]        high_nib;
		logic              nib_pend;
		logic [SKIP_W-1:0] skip;
	} strm_t;

	// What one stream byte produced.
	typedef struct packed {
		logic       emit;
		logic [7:0] out_byte;
		logic [1:0] n_cw;
		logic [1:0] n_err;
	} step_res_t;

endpackage

// File: hdl/crc_cw_byte_step.sv
module crc_cw_byte_step (
	input  crc_cw_pkg::cfg_t      cfg,
	input  crc_cw_pkg::strm_t     st,
	input  logic [7:0]            data_in,
	output crc_cw_pkg::strm_t     st_next,
	output crc_cw_pkg::step_res_t res
);

	logic [crc_cw_pkg::LEN_REG_W-1:0]    len_eff;
	logic [crc_cw_pkg::LEN_W-1:0]        r_len;
	logic [crc_cw_pkg::MAX_GEN_BITS-1:0] one_sh;
	logic [crc_cw_pkg::REM_W-1:0]        mask;
	logic [crc_cw_pkg::REM_W-1:0]        top_m;
	logic [crc_cw_pkg::REM_W-1:0]        poly_m;
	logic [crc_cw_pkg::BP_W-1:0]         dw;
	logic [crc_cw_pkg::BP_W-1:0]         cs;

	// Effective generator length, remainder mask and codeword size.
	always_comb begin
		if (cfg.gen_len < crc_cw_pkg::LEN_REG_W'(2)) begin
			len_eff = crc_cw_pkg::LEN_REG_W'(2);
		end else if (cfg.gen_len > crc_cw_pkg::LEN_REG_W'(crc_cw_pkg::MAX_GEN_BITS)) begin
			len_eff = crc_cw_pkg::LEN_REG_W'(crc_cw_pkg::MAX_GEN_BITS);
		end else begin
			len_eff = cfg.gen_len;
		end
		r_len  = crc_cw_pkg::LEN_W'(len_eff - crc_cw_pkg::LEN_REG_W'(1));
		one_sh = crc_cw_pkg::MAX_GEN_BITS'(1) << r_len;
		mask   = crc_cw_pkg::REM_W'(one_sh - crc_cw_pkg::MAX_GEN_BITS'(1));
		top_m  = mask ^ (mask >> 1);
		poly_m = crc_cw_pkg::REM_W'(cfg.gen_poly) & mask;
		dw     = (cfg.data_mode == crc_cw_pkg::MODE_BYTE) ?
			crc_cw_pkg::BP_W'(crc_cw_pkg::DW_BYTE) : crc_cw_pkg::BP_W'(crc_cw_pkg::DW_NIBBLE);
		cs     = dw + crc_cw_pkg::BP_W'(r_len);
	end

	// Eight serial shift-and-xor steps, most significant bit first.
	always_comb begin
		crc_cw_pkg::strm_t s;
		logic       b;
		logic       top;
		logic       emit;
		logic [7:0] ob;
		logic [1:0] ncw;
		logic [1:0] nerr;
		s    = st;
		b    = 1'b0;
		top  = 1'b0;
		emit = 1'b0;
		ob   = '0;
		ncw  = '0;
		nerr = '0;
		for (int k = 7; k >= 0; k--) begin
			if (s.skip != '0) begin
				s.skip = s.skip - crc_cw_pkg::SKIP_W'(1);
			end else begin
				b     = data_in[k];
				top   = |(s.rem & top_m);
				s.rem = ((s.rem << 1) | crc_cw_pkg::REM_W'(b)) & mask;
				if (top) begin
					s.rem = s.rem ^ poly_m;
				end
				if (s.bit_pos < dw) begin
					s.data = {s.data[6:0], b};
				end
				s.bit_pos = s.bit_pos + crc_cw_pkg::BP_W'(1);
				if (s.bit_pos >= cs) begin
					ncw = ncw + 2'd1;
					if (s.rem != '0) begin
						nerr = nerr + 2'd1;
					end
					if (cfg.data_mode == crc_cw_pkg::MODE_BYTE) begin
						emit = 1'b1;
						ob   = s.data;
					end else if (s.nib_pend) begin
						emit       = 1'b1;
						ob         = {s.high_nib, s.data[3:0]};
						s.nib_pend = 1'b0;
					end else begin
						s.high_nib = s.data[3:0];
						s.nib_pend = 1'b1;
					end
					s.rem     = '0;
					s.bit_pos = '0;
					s.data    = '0;
				end
			end
		end
		st_next      = s;
		res.emit     = emit;
		res.out_byte = ob;
		res.n_cw     = ncw;
		res.n_err    = nerr;
	end

endmodule

// File: hdl/crc_codeword_stream_checker_core.sv
// CRC codeword stream checker.
//
// The input channel (in_valid, in_stall) carries one stream byte per word
// together with its is_first and is_last marks. A word marked is_first holds
// the pad count, clears the stream state and both counters. The output channel
// (out_valid, out_stall) carries one result word whenever a data byte completes
// or the input word was marked is_last; other input words give no result.
// Configuration is written through cfg_we, cfg_index and cfg_wdata, one register
// per clock, by the user only while the block is idle; the block does not check this.
//
// An accepted word is held in the input register, where all eight bit steps
// of the remainder division run; the result is then captured in the output
// register, which drives out_valid. One word is accepted every cycle while
// in_stall is low.
//
// Reset clears the stream state, the counters and both valid flags, and loads
// the default generator x^3+x+1 with 8-bit datawords. When the receiver
// stalls with a result waiting, a word that produces no result still passes;
// a word that produces one waits in the input register, and in_stall rises.
module crc_codeword_stream_checker_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          in_byte,
	input  logic                                is_first,
	input  logic                                is_last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                byte_valid,
	output logic [7:0]                          decoded_byte,
	output logic [crc_cw_pkg::TOTAL_W-1:0]      codeword_total,
	output logic [crc_cw_pkg::TOTAL_W-1:0]      error_total,
	output logic                                summary_flag,
	input  logic                                cfg_we,
	input  logic [crc_cw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [crc_cw_pkg::CFG_W-1:0]        cfg_wdata
);

	crc_cw_pkg::cfg_t      cfg_q;
	crc_cw_pkg::strm_t     st_q;
	crc_cw_pkg::strm_t     st_step;
	crc_cw_pkg::strm_t     st_nx;
	crc_cw_pkg::step_res_t step_res;

	logic [crc_cw_pkg::COUNT_BITS-1:0] cw_q;
	logic [crc_cw_pkg::COUNT_BITS-1:0] err_q;
	logic [crc_cw_pkg::COUNT_BITS-1:0] cw_nx;
	logic [crc_cw_pkg::COUNT_BITS-1:0] err_nx;
	logic [crc_cw_pkg::COUNT_BITS:0]   cw_sum;
	logic [crc_cw_pkg::COUNT_BITS:0]   err_sum;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	// Output register.
	logic       out_valid_q;
	logic       byte_valid_q;
	logic [7:0] decoded_q;
	logic [crc_cw_pkg::TOTAL_W-1:0] cw_out_q;
	logic [crc_cw_pkg::TOTAL_W-1:0] err_out_q;
	logic       summary_q;

	logic       in_accept;
	logic       adv;
	logic       res_needed;
	logic       emit;
	logic [7:0] out_byte;
	logic [crc_cw_pkg::SKIP_W-1:0] pad;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gen_poly  <= crc_cw_pkg::GEN_POLY_RST;
			cfg_q.gen_len   <= crc_cw_pkg::GEN_LEN_RST;
			cfg_q.data_mode <= crc_cw_pkg::DATA_MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crc_cw_pkg::CFG_GEN_POLY: begin
					cfg_q.gen_poly <= cfg_wdata[crc_cw_pkg::MAX_GEN_BITS-1:0];
				end
				crc_cw_pkg::CFG_GEN_LEN: begin
					cfg_q.gen_len <= cfg_wdata[crc_cw_pkg::LEN_REG_W-1:0];
				end
				crc_cw_pkg::CFG_DATA_MODE: begin
					cfg_q.data_mode <= cfg_wdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// The eight bit steps for the word held in the input register.
	crc_cw_byte_step u_step (
		.cfg     (cfg_q),
		.st      (st_q),
		.data_in (byte_s1),
		.st_next (st_step),
		.res     (step_res)
	);

	assign pad = (byte_s1 > 8'(crc_cw_pkg::PAD_MAX)) ?
		crc_cw_pkg::SKIP_W'(crc_cw_pkg::PAD_MAX) : byte_s1[crc_cw_pkg::SKIP_W-1:0];

	// Next stream state and counters. A pad count word starts a fresh stream;
	// counters add the completions of this word and stop at their maximum.
	always_comb begin
		cw_sum  = {1'b0, cw_q} + (crc_cw_pkg::COUNT_BITS + 1)'(step_res.n_cw);
		err_sum = {1'b0, err_q} + (crc_cw_pkg::COUNT_BITS + 1)'(step_res.n_err);
		if (first_s1) begin
			st_nx      = '0;
			st_nx.skip = pad;
			cw_nx      = '0;
			err_nx     = '0;
			emit       = 1'b0;
			out_byte   = '0;
		end else begin
			st_nx    = st_step;
			cw_nx    = cw_sum[crc_cw_pkg::COUNT_BITS] ? '1 : cw_sum[crc_cw_pkg::COUNT_BITS-1:0];
			err_nx   = err_sum[crc_cw_pkg::COUNT_BITS] ? '1 :
				err_sum[crc_cw_pkg::COUNT_BITS-1:0];
			emit     = step_res.emit;
			out_byte = step_res.emit ? step_res.out_byte : 8'd0;
		end
		// The final word drops any partial codeword, lone nibble and pad count.
		if (last_s1) begin
			st_nx = '0;
		end
	end

	assign res_needed = emit || last_s1;

	// The input register moves on when its word gives no result or the
	// output register is free or being emptied in this cycle.
	assign adv       = valid_s1 && (!res_needed || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1  <= in_byte;
			first_s1 <= is_first;
			last_s1  <= is_last;
		end
	end

	// Stream state and counters are committed as the word leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			cw_q  <= '0;
			err_q <= '0;
		end else if (adv) begin
			st_q  <= st_nx;
			cw_q  <= cw_nx;
			err_q <= err_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res_needed) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_needed) begin
			byte_valid_q <= emit;
			decoded_q    <= out_byte;
			cw_out_q     <= crc_cw_pkg::TOTAL_W'(cw_nx);
			err_out_q    <= crc_cw_pkg::TOTAL_W'(err_nx);
			summary_q    <= last_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign byte_valid     = byte_valid_q;
	assign decoded_byte   = decoded_q;
	assign codeword_total = cw_out_q;
	assign error_total    = err_out_q;
	assign summary_flag   = summary_q;

	// The input side only stalls while a word waits in the input register.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with an empty input register");

	// Errors are only counted on checked codewords.
	a_err_le_cw: assert property (@(posedge clk) disable iff (!arst_n)
		err_q <= cw_q)
		else $error("error count above codeword count");

	// A final word leaves no partial codeword or nibble behind.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (st_q.bit_pos == '0 && !st_q.nib_pend && st_q.skip == '0))
		else $error("stream state kept after the final word");

	// A result with no completed byte carries a zero data byte.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (decoded_byte == 8'd0))
		else $error("data byte set without byte_valid");

endmodule
